[rtl/core/snfcs_pkg.sv]
package snfcs_pkg;

    // Geometry defaults; both must be powers of two.
    localparam int unsigned PAGE_BYTES_DEFAULT   = 256;
    localparam int unsigned SECTOR_BYTES_DEFAULT = 4096;

    localparam logic [24:0] FLASH_SIZE_RESET = 25'h1000000;
    localparam logic [24:0] LENGTH_MAX       = 25'h1000000;

    // Request and acknowledgement codes carried on the input tuser.
    localparam logic [2:0] ACT_READ       = 3'd0;
    localparam logic [2:0] ACT_PROGRAM    = 3'd1;
    localparam logic [2:0] ACT_ERASE      = 3'd2;
    localparam logic [2:0] ACT_QUAD       = 3'd3;
    localparam logic [2:0] ACT_FRAME_DONE = 3'd4;

    localparam logic [1:0] OPER_PROGRAM = 2'd1;
    localparam logic [1:0] OPER_ERASE   = 2'd2;

    localparam logic [1:0] KIND_FRAME    = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;

    localparam logic [1:0] RES_OK          = 2'd0;
    localparam logic [1:0] RES_UNEXPECTED  = 2'd1;
    localparam logic [1:0] RES_EMPTY_ERASE = 2'd2;

    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_RDSR1 = 8'h05;
    localparam logic [7:0] OP_RDSR2 = 8'h35;
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRSR  = 8'h01;
    localparam logic [7:0] OP_PP    = 8'h02;
    localparam logic [7:0] OP_SE    = 8'h20;
    localparam logic [7:0] OP_CE    = 8'h60;

    localparam int unsigned BUSY_BIT = 0;
    localparam int unsigned QE_BIT   = 1;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_READ     = 8'b0000_0010,
        PH_WEN      = 8'b0000_0100,
        PH_WEN_CHIP = 8'b0000_1000,
        PH_CMD      = 8'b0001_0000,
        PH_POLL     = 8'b0010_0000,
        PH_SR1      = 8'b0100_0000,
        PH_SR2      = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [24:0] bytes_done;
        logic [1:0]  result_code;
        logic        keep_selected;
        logic [24:0] rx_count;
        logic [7:0]  status_byte_two;
        logic [7:0]  status_byte_one;
        logic [8:0]  tx_count;
        logic        send_address;
        logic [23:0] frame_address;
        logic        send_opcode;
        logic [7:0]  opcode;
    } result_t;

endpackage

[rtl/core/spi_nor_flash_command_sequencer.sv]
// SPI NOR flash command sequencer. Each input transaction is a host request (read, program,
// erase, quad-enable update) or a frame-done acknowledgement from the SPI engine, and each one
// produces exactly one output transaction: the next SPI frame descriptor or a completion.
// The decision is made combinationally from the input and the sequencer state and lands in an
// output register, so one transaction is accepted per clock as long as the output side keeps
// taking results; a stalled output holds one result and backpressures the input. PAGE_BYTES
// and SECTOR_BYTES must be powers of two. The user must write the flash size register through
// cfg_we/cfg_wdata only while no request is in progress; the block does not enforce this.
module spi_nor_flash_command_sequencer #(
    parameter int unsigned PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEFAULT,
    parameter int unsigned SECTOR_BYTES = snfcs_pkg::SECTOR_BYTES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [24:0]  cfg_wdata,      // flash_size_bytes
    input  logic         s_tvalid,
    output logic         s_tready,
    // address[23:0], length[48:24], quad_on[49], rx_status[57:50], zero[63:58]
    input  logic [63:0]  s_tdata,
    input  logic [2:0]   s_tuser,        // action[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // opcode[7:0], send_opcode[8], frame_address[32:9], send_address[33],
    // tx_count[42:34], status_byte_one[50:43], status_byte_two[58:51],
    // rx_count[83:59], keep_selected[84], result_code[86:85], bytes_done[111:87]
    output logic [111:0] m_tdata,
    output logic [1:0]   m_tuser         // kind[1:0]
);

    localparam int unsigned PAGE_LOG2   = $clog2(PAGE_BYTES);
    localparam int unsigned SECTOR_LOG2 = $clog2(SECTOR_BYTES);
    localparam logic [PAGE_LOG2:0] PAGE_SPAN   = (PAGE_LOG2 + 1)'(PAGE_BYTES);
    localparam logic [25:0]        SECTOR_STEP = 26'(SECTOR_BYTES);

    logic [24:0]       flash_size_reg;
    snfcs_pkg::phase_t phase_reg, phase_next;
    logic [1:0]        operation_reg, operation_next;
    logic [24:0]       cur_addr_reg, cur_addr_next;
    logic [24:0]       end_addr_reg, end_addr_next;
    logic [24:0]       done_count_reg, done_count_next;
    logic [7:0]        status_one_reg, status_one_next;
    logic [7:0]        status_two_reg, status_two_next;
    logic              quad_req_reg, quad_req_next;

    logic                 out_valid_reg;
    snfcs_pkg::result_t   out_reg, res;

    logic        accept;
    logic [2:0]  action;
    logic [23:0] in_addr;
    logic [24:0] in_len_raw, in_len;
    logic        in_quad;
    logic [7:0]  in_rx;

    logic [PAGE_LOG2:0] page_room;
    logic [24:0]        remain, chunk;
    logic [24:0]        prog_addr;
    logic [25:0]        sector_next;
    logic [24:0]        req_end;
    logic [24:0]        erase_align;
    logic [7:0]         wrsr_two;

    function automatic snfcs_pkg::result_t make_frame(
        input logic [7:0]  op,
        input logic        sop,
        input logic [23:0] addr,
        input logic        sad,
        input logic [8:0]  tx,
        input logic [7:0]  s1,
        input logic [7:0]  s2,
        input logic [24:0] rx,
        input logic        keep
    );
        snfcs_pkg::result_t r;
        r               = '0;
        r.kind          = snfcs_pkg::KIND_FRAME;
        r.opcode        = op;
        r.send_opcode   = sop;
        r.frame_address = sad ? addr : 24'd0;
        r.send_address  = sad;
        r.tx_count      = tx;
        r.status_byte_one = s1;
        r.status_byte_two = s2;
        r.rx_count      = rx;
        r.keep_selected = keep;
        return r;
    endfunction

    function automatic snfcs_pkg::result_t make_finish(
        input logic [1:0]  code,
        input logic [24:0] bytes
    );
        snfcs_pkg::result_t r;
        r             = '0;
        r.kind        = snfcs_pkg::KIND_COMPLETE;
        r.result_code = code;
        r.bytes_done  = bytes;
        return r;
    endfunction

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign action     = s_tuser;
    assign in_addr    = s_tdata[23:0];
    assign in_len_raw = s_tdata[48:24];
    assign in_quad    = s_tdata[49];
    assign in_rx      = s_tdata[57:50];
    assign in_len     = (in_len_raw > snfcs_pkg::LENGTH_MAX) ? snfcs_pkg::LENGTH_MAX : in_len_raw;

    // Program chunk: the rest of the current page, or the rest of the request if shorter.
    assign page_room = PAGE_SPAN - {1'b0, cur_addr_reg[PAGE_LOG2-1:0]};
    assign remain    = end_addr_reg - cur_addr_reg;
    assign chunk     = (25'(page_room) < remain) ? 25'(page_room) : remain;
    assign prog_addr = cur_addr_reg + chunk;

    assign sector_next = {1'b0, cur_addr_reg} + SECTOR_STEP;
    assign req_end     = {1'b0, in_addr} + in_len;
    assign erase_align = {1'b0, in_addr[23:SECTOR_LOG2], {SECTOR_LOG2{1'b0}}};

    always_comb
    begin
        wrsr_two                    = status_two_reg;
        wrsr_two[snfcs_pkg::QE_BIT] = quad_req_reg;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        operation_next  = operation_reg;
        cur_addr_next   = cur_addr_reg;
        end_addr_next   = end_addr_reg;
        done_count_next = done_count_reg;
        status_one_next = status_one_reg;
        status_two_next = status_two_reg;
        quad_req_next   = quad_req_reg;
        res             = make_finish(snfcs_pkg::RES_UNEXPECTED, 25'd0);

        if (action == snfcs_pkg::ACT_FRAME_DONE)
        begin
            unique case (phase_reg)
                snfcs_pkg::PH_READ:
                begin
                    phase_next = snfcs_pkg::PH_IDLE;
                    res        = make_finish(snfcs_pkg::RES_OK, done_count_reg);
                end
                snfcs_pkg::PH_WEN:
                begin
                    phase_next = snfcs_pkg::PH_CMD;
                    if (operation_reg == snfcs_pkg::OPER_PROGRAM)
                        res = make_frame(snfcs_pkg::OP_PP, 1'b1, cur_addr_reg[23:0], 1'b1,
                                         chunk[8:0], 8'd0, 8'd0, 25'd0, 1'b0);
                    else if (operation_reg == snfcs_pkg::OPER_ERASE)
                        res = make_frame(snfcs_pkg::OP_SE, 1'b1, cur_addr_reg[23:0], 1'b1,
                                         9'd0, 8'd0, 8'd0, 25'd0, 1'b0);
                    else
                        res = make_frame(snfcs_pkg::OP_WRSR, 1'b1, 24'd0, 1'b0,
                                         9'd2, status_one_reg, wrsr_two, 25'd0, 1'b0);
                end
                snfcs_pkg::PH_WEN_CHIP:
                begin
                    phase_next = snfcs_pkg::PH_CMD;
                    res = make_frame(snfcs_pkg::OP_CE, 1'b1, 24'd0, 1'b0,
                                     9'd0, 8'd0, 8'd0, 25'd0, 1'b0);
                end
                snfcs_pkg::PH_CMD:
                begin
                    phase_next = snfcs_pkg::PH_POLL;
                    res = make_frame(snfcs_pkg::OP_RDSR1, 1'b1, 24'd0, 1'b0,
                                     9'd0, 8'd0, 8'd0, 25'd1, 1'b1);
                end
                snfcs_pkg::PH_POLL:
                begin
                    if (in_rx[snfcs_pkg::BUSY_BIT])
                    begin
                        // Device still busy: keep chip select and clock in one more byte.
                        res = make_frame(snfcs_pkg::OP_RDSR1, 1'b0, 24'd0, 1'b0,
                                         9'd0, 8'd0, 8'd0, 25'd1, 1'b1);
                    end
                    else if (operation_reg == snfcs_pkg::OPER_PROGRAM)
                    begin
                        done_count_next = done_count_reg + chunk;
                        cur_addr_next   = prog_addr;
                        if (prog_addr < end_addr_reg)
                        begin
                            phase_next = snfcs_pkg::PH_WEN;
                            res = make_frame(snfcs_pkg::OP_WREN, 1'b1, 24'd0, 1'b0,
                                             9'd0, 8'd0, 8'd0, 25'd0, 1'b0);
                        end
                        else
                        begin
                            phase_next = snfcs_pkg::PH_IDLE;
                            res = make_finish(snfcs_pkg::RES_OK, done_count_reg + chunk);
                        end
                    end
                    else if (operation_reg == snfcs_pkg::OPER_ERASE &&
                             sector_next < {1'b0, end_addr_reg})
                    begin
                        cur_addr_next = sector_next[24:0];
                        phase_next    = snfcs_pkg::PH_WEN;
                        res = make_frame(snfcs_pkg::OP_WREN, 1'b1, 24'd0, 1'b0,
                                         9'd0, 8'd0, 8'd0, 25'd0, 1'b0);
                    end
                    else
                    begin
                        phase_next = snfcs_pkg::PH_IDLE;
                        res        = make_finish(snfcs_pkg::RES_OK, 25'd0);
                    end
                end
                snfcs_pkg::PH_SR1:
                begin
                    status_one_next = in_rx;
                    phase_next      = snfcs_pkg::PH_SR2;
                    res = make_frame(snfcs_pkg::OP_RDSR2, 1'b1, 24'd0, 1'b0,
                                     9'd0, 8'd0, 8'd0, 25'd1, 1'b0);
                end
                snfcs_pkg::PH_SR2:
                begin
                    status_two_next = in_rx;
                    phase_next      = snfcs_pkg::PH_WEN;
                    res = make_frame(snfcs_pkg::OP_WREN, 1'b1, 24'd0, 1'b0,
                                     9'd0, 8'd0, 8'd0, 25'd0, 1'b0);
                end
                default:
                begin
                    phase_next = snfcs_pkg::PH_IDLE;
                    res        = make_finish(snfcs_pkg::RES_UNEXPECTED, 25'd0);
                end
            endcase
        end
        else if (action < snfcs_pkg::ACT_FRAME_DONE && phase_reg == snfcs_pkg::PH_IDLE)
        begin
            operation_next  = action[1:0];
            done_count_next = 25'd0;
            if (action == snfcs_pkg::ACT_READ || action == snfcs_pkg::ACT_PROGRAM)
            begin
                if (in_len == 25'd0)
                begin
                    res = make_finish(snfcs_pkg::RES_OK, 25'd0);
                end
                else
                begin
                    cur_addr_next = {1'b0, in_addr};
                    end_addr_next = req_end;
                    if (action == snfcs_pkg::ACT_READ)
                    begin
                        done_count_next = in_len;
                        phase_next      = snfcs_pkg::PH_READ;
                        res = make_frame(snfcs_pkg::OP_READ, 1'b1, in_addr, 1'b1,
                                         9'd0, 8'd0, 8'd0, in_len, 1'b0);
                    end
                    else
                    begin
                        phase_next = snfcs_pkg::PH_WEN;
                        res = make_frame(snfcs_pkg::OP_WREN, 1'b1, 24'd0, 1'b0,
                                         9'd0, 8'd0, 8'd0, 25'd0, 1'b0);
                    end
                end
            end
            else if (action == snfcs_pkg::ACT_ERASE)
            begin
                if (in_addr == 24'd0 && in_len == flash_size_reg)
                begin
                    cur_addr_next = 25'd0;
                    end_addr_next = 25'd0;
                    phase_next    = snfcs_pkg::PH_WEN_CHIP;
                    res = make_frame(snfcs_pkg::OP_WREN, 1'b1, 24'd0, 1'b0,
                                     9'd0, 8'd0, 8'd0, 25'd0, 1'b0);
                end
                else
                begin
                    cur_addr_next = erase_align;
                    end_addr_next = req_end;
                    if (erase_align >= req_end)
                    begin
                        res = make_finish(snfcs_pkg::RES_EMPTY_ERASE, 25'd0);
                    end
                    else
                    begin
                        phase_next = snfcs_pkg::PH_WEN;
                        res = make_frame(snfcs_pkg::OP_WREN, 1'b1, 24'd0, 1'b0,
                                         9'd0, 8'd0, 8'd0, 25'd0, 1'b0);
                    end
                end
            end
            else
            begin
                quad_req_next = in_quad;
                phase_next    = snfcs_pkg::PH_SR1;
                res = make_frame(snfcs_pkg::OP_RDSR1, 1'b1, 24'd0, 1'b0,
                                 9'd0, 8'd0, 8'd0, 25'd1, 1'b0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_size_reg <= snfcs_pkg::FLASH_SIZE_RESET;
            phase_reg      <= snfcs_pkg::PH_IDLE;
            operation_reg  <= 2'd0;
            cur_addr_reg   <= 25'd0;
            end_addr_reg   <= 25'd0;
            done_count_reg <= 25'd0;
            status_one_reg <= 8'd0;
            status_two_reg <= 8'd0;
            quad_req_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                flash_size_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg      <= phase_next;
                operation_reg  <= operation_next;
                cur_addr_reg   <= cur_addr_next;
                end_addr_reg   <= end_addr_next;
                done_count_reg <= done_count_next;
                status_one_reg <= status_one_next;
                status_two_reg <= status_two_next;
                quad_req_reg   <= quad_req_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {out_reg.bytes_done, out_reg.result_code, out_reg.keep_selected,
                       out_reg.rx_count, out_reg.status_byte_two, out_reg.status_byte_one,
                       out_reg.tx_count, out_reg.send_address, out_reg.frame_address,
                       out_reg.send_opcode, out_reg.opcode};

endmodule
